@@ rtl/assert_macros.svh @@
// assertion macros for the read provenance ring
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPR_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RPR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define RPR_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define RPR_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ rtl/rpr_pkg.sv @@
// shared constants, types and helpers of the read provenance ring
// no dependencies
`default_nettype none
package rpr_pkg;
	localparam int SLOTS = 4;
	localparam int ENTRIES = 512;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ADDR_W = 32;
	localparam int ENTRY_W = 10;
	localparam int FENTRY_W = 9;
	localparam int IN_TDATA_W = 112;
	localparam int OUT_TDATA_W = 48;
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic write_slot;
		logic load_query;
		logic step;
		logic out_load;
		logic out_found;
	} rpr_cmd_t;

	typedef struct packed {
		logic q_null;
		logic hit;
		logic last;
	} rpr_status_t;

	function automatic slot_idx_t slot_inc(input slot_idx_t i);
		slot_idx_t r;
		if (32'(i) == SLOTS - 1) r = '0;
		else r = i + slot_idx_t'(1);
		return r;
	endfunction

	function automatic slot_idx_t slot_dec(input slot_idx_t i);
		slot_idx_t r;
		if (i == '0) r = slot_idx_t'(SLOTS - 1);
		else r = i - slot_idx_t'(1);
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/read_provenance_ring.sv @@
// read provenance ring: a record beat, or a query with null address or zero length,
// gives its result beat in the next cycle; any other query scans the slots newest
// first, one slot per cycle through the shared containment compare, until a hit
// or all SLOTS slots are seen. a new beat is taken only in idle, once the previous
// result beat has been handed off, so no beat is taken while a query scans.
// arst_n clears all slots to empty, the ring head to slot 0 and the output valid.
`default_nettype none
`include "assert_macros.svh"
module read_provenance_ring (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// buffer_address, byte_length, file_offset, file_entry, zero pad
	input  wire logic [rpr_pkg::IN_TDATA_W-1:0]     s_tdata,
	// req_type
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// found_entry, found_offset, zero pad
	output logic [rpr_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// found
	output logic                                    m_tuser
);
	rpr_pkg::rpr_cmd_t    cmd;
	rpr_pkg::rpr_status_t st;

	rpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.st        (st)
	);

	rpr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.out_data  (m_tdata),
		.out_found (m_tuser)
	);

	`RPR_ASSERT_IMP(a_accept_out_free, clk, arst_n, s_tvalid && s_tready, !m_tvalid || m_tready)
	`RPR_ASSERT_NXT(a_record_result, clk, arst_n,
		s_tvalid && s_tready && (s_tuser == rpr_pkg::REQ_RECORD), m_tvalid && !m_tuser)
	`RPR_ASSERT_IMP(a_miss_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0)
endmodule
`default_nettype wire

@@ rtl/rpr_datapath.sv @@
// slot registers, ring pointers, one-slot-per-cycle containment check, output register
// depends on rpr_pkg
`default_nettype none
module rpr_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rpr_pkg::rpr_cmd_t                 cmd,
	output rpr_pkg::rpr_status_t                   st,
	input  wire logic [rpr_pkg::IN_TDATA_W-1:0]    in_data,
	output logic [rpr_pkg::OUT_TDATA_W-1:0]        out_data,
	output logic                                   out_found
);
	logic [rpr_pkg::ADDR_W-1:0]   addr;
	logic [rpr_pkg::ADDR_W-1:0]   len;
	logic [rpr_pkg::ADDR_W-1:0]   foff;
	logic [rpr_pkg::ENTRY_W-1:0]  ent;
	logic                         ent_ok;
	logic                         rec_ok;

	logic                         valid_q [rpr_pkg::SLOTS];
	logic [rpr_pkg::ADDR_W-1:0]   start_q [rpr_pkg::SLOTS];
	logic [rpr_pkg::ADDR_W:0]     end_q   [rpr_pkg::SLOTS];
	logic [rpr_pkg::ADDR_W-1:0]   base_q  [rpr_pkg::SLOTS];
	logic [rpr_pkg::FENTRY_W-1:0] entry_q [rpr_pkg::SLOTS];
	rpr_pkg::slot_idx_t           head_q;
	rpr_pkg::slot_idx_t           ptr_q;

	logic [rpr_pkg::ADDR_W-1:0]   qaddr_q;
	logic [rpr_pkg::ADDR_W:0]     qend_q;
	logic [rpr_pkg::FENTRY_W-1:0] oentry_q;
	logic [rpr_pkg::ADDR_W-1:0]   ooff_q;
	logic                         ofound_q;

	assign addr = in_data[31:0];
	assign len  = in_data[63:32];
	assign foff = in_data[95:64];
	assign ent  = in_data[105:96];
	assign ent_ok = !ent[rpr_pkg::ENTRY_W-1] &&
		(32'(ent[rpr_pkg::FENTRY_W-1:0]) < 32'(rpr_pkg::ENTRIES));
	assign rec_ok = (addr != '0) && (len != '0);

	assign st.q_null = (addr == '0) || (len == '0);
	assign st.hit = valid_q[ptr_q] && (qaddr_q >= start_q[ptr_q]) && (qend_q <= end_q[ptr_q]);
	assign st.last = (ptr_q == head_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rpr_pkg::SLOTS; i++) valid_q[i] <= 1'b0;
			head_q <= '0;
		end else if (cmd.write_slot && rec_ok) begin
			valid_q[head_q] <= ent_ok;
			head_q <= rpr_pkg::slot_inc(head_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_slot && rec_ok) begin
			start_q[head_q] <= addr;
			end_q[head_q]   <= {1'b0, addr} + {1'b0, len};
			base_q[head_q]  <= foff - addr;
			entry_q[head_q] <= ent[rpr_pkg::FENTRY_W-1:0];
		end
		if (cmd.load_query) begin
			qaddr_q <= addr;
			qend_q  <= {1'b0, addr} + {1'b0, len};
			ptr_q   <= rpr_pkg::slot_dec(head_q);
		end else if (cmd.step) begin
			ptr_q <= rpr_pkg::slot_dec(ptr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofound_q <= 1'b0;
			oentry_q <= '0;
			ooff_q   <= '0;
		end else if (cmd.out_load) begin
			ofound_q <= cmd.out_found;
			oentry_q <= cmd.out_found ? entry_q[ptr_q] : '0;
			ooff_q   <= cmd.out_found ? (base_q[ptr_q] + qaddr_q) : '0;
		end
	end

	assign out_data = {7'b0, ooff_q, oentry_q};
	assign out_found = ofound_q;
endmodule
`default_nettype wire

@@ rtl/rpr_ctrl.sv @@
// controller: accepts beats, runs the newest-first slot scan, holds result valid
// depends on rpr_pkg
`default_nettype none
module rpr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_kind,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rpr_pkg::rpr_cmd_t         cmd,
	input  wire rpr_pkg::rpr_status_t st
);
	typedef enum logic {IDLE, SCAN} state_t;
	state_t state_q;
	logic   accept;
	logic   done;

	assign in_ready = (state_q == IDLE) && (!out_valid || out_ready);
	assign accept = in_valid && in_ready;
	assign done = (state_q == SCAN) && (st.hit || st.last);

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE: begin
				if (accept) begin
					if (in_kind == rpr_pkg::REQ_RECORD) begin
						cmd.write_slot = 1'b1;
						cmd.out_load = 1'b1;
					end else if (st.q_null) begin
						cmd.out_load = 1'b1;
					end else begin
						cmd.load_query = 1'b1;
					end
				end
			end
			SCAN: begin
				if (done) begin
					cmd.out_load = 1'b1;
					cmd.out_found = st.hit;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (cmd.load_query) state_q <= SCAN;
				SCAN: if (done) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire
